@@ hdl/hpdm_pkg.sv @@
// package for the heading pid drive mixer: word types, register indexes,
// fixed-point widths and register reset values; no dependencies
`default_nettype none

package hpdm_pkg;

  localparam int unsigned HEAD_W         = 16;
  localparam int unsigned SPEED_W        = 8;
  localparam int unsigned GAIN_W         = 16;
  localparam int unsigned GAIN_FRAC_BITS = 12;
  localparam int unsigned HEAD_FRAC_BITS = 4;
  localparam int unsigned SUM_WIDTH      = 32;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // derived datapath widths
  localparam int unsigned ERR_W   = HEAD_W + 1;
  localparam int unsigned DERIV_W = ERR_W + 1;
  localparam int unsigned PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int unsigned PROD_D_W = GAIN_W + 1 + DERIV_W;
  localparam int unsigned PROD_I_W = GAIN_W + 1 + SUM_WIDTH;
  localparam int unsigned TOTAL_W  = PROD_I_W + 1;
  localparam int unsigned SHIFT    = GAIN_FRAC_BITS + HEAD_FRAC_BITS;
  localparam int unsigned CORR_W   = TOTAL_W - SHIFT;
  localparam int unsigned MIX_W    = CORR_W + 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KI       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KD       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_LIM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_LIM  = 3'd6;

  localparam logic [GAIN_W-1:0]  KP_RESET      = 16'd10240;
  localparam logic [GAIN_W-1:0]  KI_RESET      = 16'd41;
  localparam logic [GAIN_W-1:0]  KD_RESET      = 16'd2048;
  localparam logic [SPEED_W-1:0] FWD_LIM_RESET = 8'd120;
  localparam logic [SPEED_W-1:0] REV_LIM_RESET = 8'd100;

  typedef struct packed {
    logic              op;
    logic [HEAD_W-1:0] measured_heading;
  } in_word_t;

  typedef struct packed {
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
    logic               updated;
  } out_word_t;

endpackage

`default_nettype wire

@@ hdl/heading_pid_drive_mixer.sv @@
// pid heading hold with differential drive mixing, four register stages
// depends on hpdm_pkg
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+--------------------------------
//  in      | input     | in_valid_i/in_stall_o   | op, measured_heading
//  out     | output    | out_valid_o/out_stall_i | left_speed, right_speed, updated
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one word per cycle sustained while out_stall_i is low; an accepted word passes
// through the input register, error/integral stage, gain multiply stage,
// then sum, shift, mix and clamp into the output register.
// the integral and last error update as a word with nonzero error leaves the input register.
// reset clears the integral, last error, held speeds and all valid bits.
// out_stall_i holds a valid output word and each full stage behind it; in_stall_o rises only when all are full.
`default_nettype none

module heading_pid_drive_mixer
  import hpdm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire in_word_t              in_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      out_word_t             out_data_o,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  logic [HEAD_W-1:0]  target_q;
  logic [SPEED_W-1:0] base_q;
  logic [GAIN_W-1:0]  kp_q, ki_q, kd_q;
  logic [SPEED_W-1:0] fwd_lim_q, rev_lim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      base_q    <= '0;
      kp_q      <= KP_RESET;
      ki_q      <= KI_RESET;
      kd_q      <= KD_RESET;
      fwd_lim_q <= FWD_LIM_RESET;
      rev_lim_q <= REV_LIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TARGET:  target_q  <= cfg_data_i[HEAD_W-1:0];
        CFG_BASE:    base_q    <= cfg_data_i[SPEED_W-1:0];
        CFG_KP:      kp_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_KI:      ki_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_KD:      kd_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_FWD_LIM: fwd_lim_q <= cfg_data_i[SPEED_W-1:0];
        CFG_REV_LIM: rev_lim_q <= cfg_data_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and flow control
  logic s0_valid_q, s1_valid_q, s2_valid_q, out_valid_q;
  logic out_en, s2_rdy, s1_rdy, s0_rdy;

  assign out_en = !out_valid_q || !out_stall_i;
  assign s2_rdy = !s2_valid_q || out_en;
  assign s1_rdy = !s1_valid_q || s2_rdy;
  assign s0_rdy = !s0_valid_q || s1_rdy;
  assign in_stall_o = !s0_rdy;

  logic s0_load, s1_load, s2_load, out_load;
  assign s0_load  = in_valid_i && s0_rdy;
  assign s1_load  = s0_valid_q && s1_rdy;
  assign s2_load  = s1_valid_q && s2_rdy;
  assign out_load = s2_valid_q && out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s0_rdy) s0_valid_q <= in_valid_i;
      if (s1_rdy) s1_valid_q <= s0_valid_q;
      if (s2_rdy) s2_valid_q <= s1_valid_q;
      if (out_en) out_valid_q <= s2_valid_q;
    end
  end

  // input register
  in_word_t s0_word_q;

  always_ff @(posedge clk_i) begin
    if (s0_load) begin
      s0_word_q <= in_data_i;
    end
  end

  // error, saturating integral and derivative
  logic signed [ERR_W-1:0]     err;
  logic signed [SUM_WIDTH:0]   sum_ext;
  logic signed [SUM_WIDTH-1:0] sum_d;
  logic signed [DERIV_W-1:0]   deriv;
  logic                        err_zero;
  logic signed [SUM_WIDTH-1:0] err_sum_q;
  logic signed [ERR_W-1:0]     last_err_q;

  always_comb begin
    err = $signed({target_q[HEAD_W-1], target_q})
        - $signed({s0_word_q.measured_heading[HEAD_W-1], s0_word_q.measured_heading});
    err_zero = (err == '0);
    sum_ext = $signed({err_sum_q[SUM_WIDTH-1], err_sum_q})
            + $signed({{(SUM_WIDTH+1-ERR_W){err[ERR_W-1]}}, err});
    if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
      sum_d = sum_ext[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                 : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_d = sum_ext[SUM_WIDTH-1:0];
    end
    deriv = $signed({err[ERR_W-1], err}) - $signed({last_err_q[ERR_W-1], last_err_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_sum_q  <= '0;
      last_err_q <= '0;
    end else if (s1_load && !err_zero) begin
      err_sum_q  <= sum_d;
      last_err_q <= err;
    end
  end

  logic                        s1_op_q, s1_zero_q;
  logic signed [ERR_W-1:0]     s1_err_q;
  logic signed [DERIV_W-1:0]   s1_deriv_q;
  logic signed [SUM_WIDTH-1:0] s1_sum_q;

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_op_q    <= s0_word_q.op;
      s1_zero_q  <= err_zero;
      s1_err_q   <= err;
      s1_deriv_q <= deriv;
      s1_sum_q   <= sum_d;
    end
  end

  // gain products
  logic signed [GAIN_W:0]     kp_s, ki_s, kd_s;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [PROD_I_W-1:0] prod_i;

  assign kp_s   = $signed({1'b0, kp_q});
  assign ki_s   = $signed({1'b0, ki_q});
  assign kd_s   = $signed({1'b0, kd_q});
  assign prod_p = kp_s * s1_err_q;
  assign prod_d = kd_s * s1_deriv_q;
  assign prod_i = ki_s * s1_sum_q;

  logic                       s2_op_q, s2_zero_q;
  logic signed [PROD_P_W-1:0] s2_p_q;
  logic signed [PROD_D_W-1:0] s2_d_q;
  logic signed [PROD_I_W-1:0] s2_i_q;

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_op_q   <= s1_op_q;
      s2_zero_q <= s1_zero_q;
      s2_p_q    <= prod_p;
      s2_d_q    <= prod_d;
      s2_i_q    <= prod_i;
    end
  end

  // sum, floor shift, mix and clamp
  logic signed [TOTAL_W-1:0] total;
  logic signed [CORR_W-1:0]  corr;
  logic signed [MIX_W-1:0]   base_ext, corr_ext, mix_l, mix_r;
  logic [SPEED_W-1:0]        limit, left_c, right_c;
  out_word_t                 out_d, out_q;

  function automatic logic [SPEED_W-1:0] clamp_speed(
    input logic signed [MIX_W-1:0] v,
    input logic [SPEED_W-1:0]      lim
  );
    logic [SPEED_W-1:0] res;
    if (v[MIX_W-1]) begin
      res = '0;
    end else if (v > $signed({{(MIX_W-SPEED_W){1'b0}}, lim})) begin
      res = lim;
    end else begin
      res = v[SPEED_W-1:0];
    end
    return res;
  endfunction

  always_comb begin
    total = $signed({{(TOTAL_W-PROD_P_W){s2_p_q[PROD_P_W-1]}}, s2_p_q})
          + $signed({{(TOTAL_W-PROD_D_W){s2_d_q[PROD_D_W-1]}}, s2_d_q})
          + $signed({{(TOTAL_W-PROD_I_W){s2_i_q[PROD_I_W-1]}}, s2_i_q});
    corr     = total[TOTAL_W-1:SHIFT];
    base_ext = $signed({{(MIX_W-SPEED_W){1'b0}}, base_q});
    corr_ext = $signed({{(MIX_W-CORR_W){corr[CORR_W-1]}}, corr});
    if (s2_op_q) begin
      mix_l = base_ext + corr_ext;
      mix_r = base_ext - corr_ext;
      limit = rev_lim_q;
    end else begin
      mix_l = base_ext - corr_ext;
      mix_r = base_ext + corr_ext;
      limit = fwd_lim_q;
    end
    left_c  = clamp_speed(mix_l, limit);
    right_c = clamp_speed(mix_r, limit);
    // the output register doubles as the held speeds
    if (s2_zero_q) begin
      out_d.left_speed  = out_q.left_speed;
      out_d.right_speed = out_q.right_speed;
      out_d.updated     = 1'b0;
    end else begin
      out_d.left_speed  = left_c;
      out_d.right_speed = right_c;
      out_d.updated     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hdl/hpdm_checker.sv @@
// port-level checker for heading_pid_drive_mixer, attached by bind
// depends on hpdm_pkg
`default_nettype none

module hpdm_sva
  import hpdm_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire out_word_t             out_data_o,
  input wire logic                  cfg_valid_i,
  input wire logic                  cfg_ready_o,
  input wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [SPEED_W-1:0] last_left_q, last_right_q, base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_left_q  <= '0;
      last_right_q <= '0;
      base_q       <= '0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        last_left_q  <= out_data_o.left_speed;
        last_right_q <= out_data_o.right_speed;
      end
      if (cfg_valid_i && cfg_ready_o && cfg_index_i == CFG_BASE) begin
        base_q <= cfg_data_i[SPEED_W-1:0];
      end
    end
  end

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  // nothing pending on out means the pipeline has room
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // held word repeats the last delivered speeds
  a_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.updated |->
      out_data_o.left_speed == last_left_q && out_data_o.right_speed == last_right_q)
    else $error("held speeds differ from last word");

  // mixing never steers both wheels above base speed
  a_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.updated |->
      !(out_data_o.left_speed > base_q && out_data_o.right_speed > base_q))
    else $error("both wheels above base speed");

endmodule

bind heading_pid_drive_mixer hpdm_sva u_hpdm_sva (.*);

`default_nettype wire
